/* rtl/core/sdgr_pkg.sv */
// Shared types, constants and helpers for the downmix, gain ramp and peak meter block.
`timescale 1ns / 1ps

package sdgr_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 15;
	localparam int LEN_W    = 9;
	localparam int PEAK_W   = 15;
	localparam int ACC_W    = 32;
	localparam int FRAC_W   = 16;
	localparam int N_PEAKS  = 5;

	// Serial unit lengths
	localparam int MUL_STEPS = GAIN_W;
	localparam int DIV_W     = GAIN_W + FRAC_W;
	localparam int DIV_STEPS = DIV_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int PROD_W    = SAMPLE_W + GAIN_W;

	// Block length limits
	localparam logic [LEN_W-1:0] BLOCK_MAX = 9'd256;
	localparam logic [LEN_W-1:0] BLOCK_MIN = 9'd1;

	// Saturation limits
	localparam logic [PEAK_W-1:0]       PEAK_SAT = 15'h7FFF;
	localparam logic signed [SAMPLE_W:0] OUT_MAX = 17'sd32767;
	localparam logic signed [SAMPLE_W:0] OUT_MIN = -17'sd32768;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int APB_W  = 32;
	localparam logic REG_SEL_USER_GAIN = 1'b0;
	localparam logic REG_SEL_MUSIC_ON  = 1'b1;

	// Peak slots
	localparam int PK_MONO  = 0;
	localparam int PK_LEFT  = 1;
	localparam int PK_RIGHT = 2;
	localparam int PK_MIC1  = 3;
	localparam int PK_MIC2  = 4;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_pcm;
		logic signed [SAMPLE_W-1:0] right_pcm;
		logic signed [SAMPLE_W-1:0] mic1_sample;
		logic signed [SAMPLE_W-1:0] mic2_pcm;
		logic [LEN_W-1:0]           block_length;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       block_end;
		logic [PEAK_W-1:0]          peak_mono;
		logic [PEAK_W-1:0]          peak_left;
		logic [PEAK_W-1:0]          peak_right;
		logic [PEAK_W-1:0]          peak_mic1;
		logic [PEAK_W-1:0]          peak_mic2;
	} result_t;

	typedef logic [N_PEAKS-1:0][SAMPLE_W-1:0] mag_vec_t;
	typedef logic [N_PEAKS-1:0][PEAK_W-1:0]   peak_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_RUN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	// Magnitude of a signed sample; the most negative value maps to 32768
	function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] x);
		logic [SAMPLE_W-1:0] u;
		u = x;
		return x[SAMPLE_W-1] ? (~u + 16'd1) : u;
	endfunction

endpackage

/* rtl/core/sdgr_mul.sv */
// Bit-serial shift-add multiplier: unsigned magnitude times Q15 gain.
`timescale 1ns / 1ps

module sdgr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdgr_pkg::SAMPLE_W-1:0] mcand,
	input  logic [sdgr_pkg::GAIN_W-1:0]   mplier,
	output logic                          busy,
	output logic [sdgr_pkg::PROD_W-1:0]   product
);
	import sdgr_pkg::*;

	logic [PROD_W-1:0]    p_q;
	logic [SAMPLE_W-1:0]  mc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [SAMPLE_W:0]    sum;

	// Add the multiplicand into the upper half when the low bit is set
	always_comb begin
		sum = {1'b0, p_q[PROD_W-1:GAIN_W]} + (p_q[0] ? {1'b0, mc_q} : '0);
	end

	// Control: count one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: load operands, then shift right with partial sums
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			p_q  <= {{SAMPLE_W{1'b0}}, mplier};
		end else if (busy_q) begin
			p_q <= {sum, p_q[GAIN_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = p_q;

endmodule

/* rtl/core/sdgr_div.sv */
// Bit-serial restoring divider for the ramp step, with sign applied at the end.
`timescale 1ns / 1ps

module sdgr_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              neg,
	input  logic [sdgr_pkg::DIV_W-1:0]        dividend,
	input  logic [sdgr_pkg::LEN_W-1:0]        divisor,
	output logic                              busy,
	output logic signed [sdgr_pkg::ACC_W-1:0] quotient
);
	import sdgr_pkg::*;

	logic [LEN_W-1:0]      rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [LEN_W-1:0]      dvs_q;
	logic                  neg_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  run_q;
	logic                  fix_q;
	logic signed [ACC_W-1:0] quot_q;
	logic [LEN_W:0]        trial;
	logic [LEN_W:0]        diff;
	logic                  ge;

	// One quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Control: iterate over the quotient bits, then apply the sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fix_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			fix_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				run_q <= 1'b0;
				fix_q <= 1'b1;
			end
		end else begin
			fix_q <= 1'b0;
		end
	end

	// Datapath: partial remainder and quotient shift together
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			neg_q <= neg;
		end else if (run_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end else if (fix_q) begin
			quot_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		end
	end

	assign busy     = run_q | fix_q;
	assign quotient = quot_q;

endmodule

/* rtl/core/sdgr_peak.sv */
// Five-channel peak magnitude meter with saturation to the peak field width.
`timescale 1ns / 1ps

module sdgr_peak (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 clr,
	input  sdgr_pkg::mag_vec_t   mags,
	output sdgr_pkg::peak_vec_t  peaks
);
	import sdgr_pkg::*;

	peak_vec_t pk_q;
	peak_vec_t pk_nxt;
	peak_vec_t sat;

	// Saturate each magnitude, then keep the larger or restart on a new block
	always_comb begin
		for (int k = 0; k < N_PEAKS; k++) begin
			sat[k]    = mags[k][SAMPLE_W-1] ? PEAK_SAT : mags[k][PEAK_W-1:0];
			pk_nxt[k] = (clr || (sat[k] > pk_q[k])) ? sat[k] : pk_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_q <= '0;
		end else if (en) begin
			pk_q <= pk_nxt;
		end
	end

	assign peaks = pk_q;

endmodule

/* rtl/core/stereo_downmix_gain_ramp_peak_meter.sv */
// Top level: frame control, gain ramp state, configuration registers and result register.
// Frame processing time is set by the 15-step serial multiplier and, on a block's first frame,
//   by the 31-step serial divider plus its sign step.
// A new frame is taken as soon as the previous result sits in the output register.
// Reset clears the gain ramp, block counter, peaks and registers; the first frame starts a block.
`timescale 1ns / 1ps

module stereo_downmix_gain_ramp_peak_meter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sdgr_pkg::ADDR_W-1:0] paddr,
	input  logic [sdgr_pkg::APB_W-1:0]  pwdata,
	output logic [sdgr_pkg::APB_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        frame_valid,
	output logic                        frame_stall,
	input  sdgr_pkg::frame_t            frame,
	output logic                        result_valid,
	input  logic                        result_stall,
	output sdgr_pkg::result_t           result
);
	import sdgr_pkg::*;

	state_t state_q;
	state_t state_nxt;

	logic [GAIN_W-1:0]       user_gain_q;
	logic                    music_on_q;
	logic [GAIN_W-1:0]       applied_gain_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] inc_q;
	logic [LEN_W-1:0]        frames_left_q;
	logic                    blk_start_q;
	logic                    last_q;
	logic                    div_neg_q;
	logic [GAIN_W-1:0]       div_mag_q;
	frame_t                  frame_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	result_t                 result_q;
	logic                    result_valid_q;

	logic                    accept;
	logic                    cfg_wr;
	logic                    mul_start;
	logic                    div_start;
	logic                    peak_en;
	logic                    emit_load;
	logic                    mul_busy;
	logic                    div_busy;
	logic [PROD_W-1:0]       product;
	logic signed [ACC_W-1:0] div_quot;
	peak_vec_t               peaks;
	mag_vec_t                mags;

	logic [LEN_W-1:0]        len_clamp;
	logic [GAIN_W-1:0]       target;
	logic signed [GAIN_W:0]  gain_diff;
	logic signed [SAMPLE_W:0] lr_sum;
	logic signed [SAMPLE_W:0] lr_adj;
	logic signed [SAMPLE_W-1:0] mono;
	logic [SAMPLE_W-1:0]     mono_mag;
	logic [SAMPLE_W-1:0]     o_mag;
	logic signed [SAMPLE_W:0] o_full;
	logic signed [SAMPLE_W-1:0] o_sat;
	logic signed [ACC_W-1:0] inc_now;

	assign accept = frame_valid && !frame_stall;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_gain_q <= '0;
			music_on_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SEL_USER_GAIN: user_gain_q <= pwdata[GAIN_W-1:0];
				REG_SEL_MUSIC_ON:  music_on_q  <= pwdata[0];
				default:           user_gain_q <= user_gain_q;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SEL_MUSIC_ON) ? {{(APB_W-1){1'b0}}, music_on_q}
	                                               : {{(APB_W-GAIN_W){1'b0}}, user_gain_q};

	// Block setup values, taken at a block's first frame
	always_comb begin
		if (frame.block_length > BLOCK_MAX) begin
			len_clamp = BLOCK_MAX;
		end else if (frame.block_length == '0) begin
			len_clamp = BLOCK_MIN;
		end else begin
			len_clamp = frame.block_length;
		end
		target    = music_on_q ? user_gain_q : '0;
		gain_diff = $signed({1'b0, target}) - $signed({1'b0, applied_gain_q});
	end

	// Mono downmix, halved with truncation toward zero
	always_comb begin
		lr_sum   = $signed({frame_q.left_pcm[SAMPLE_W-1], frame_q.left_pcm})
		         + $signed({frame_q.right_pcm[SAMPLE_W-1], frame_q.right_pcm});
		lr_adj   = lr_sum + $signed({{SAMPLE_W{1'b0}}, lr_sum[SAMPLE_W]});
		mono     = lr_adj[SAMPLE_W:1];
		mono_mag = mag16(mono);
	end

	// Scaled output: drop the Q15 fraction of the magnitude, restore sign, saturate
	always_comb begin
		o_mag  = product[PROD_W-1:GAIN_W];
		o_full = mono[SAMPLE_W-1] ? -$signed({1'b0, o_mag}) : $signed({1'b0, o_mag});
		if (o_full > OUT_MAX) begin
			o_sat = OUT_MAX[SAMPLE_W-1:0];
		end else if (o_full < OUT_MIN) begin
			o_sat = OUT_MIN[SAMPLE_W-1:0];
		end else begin
			o_sat = o_full[SAMPLE_W-1:0];
		end
		inc_now = blk_start_q ? div_quot : inc_q;
	end

	// Magnitudes for the peak meter
	always_comb begin
		mags[PK_MONO]  = mono_mag;
		mags[PK_LEFT]  = mag16(frame_q.left_pcm);
		mags[PK_RIGHT] = mag16(frame_q.right_pcm);
		mags[PK_MIC1]  = mag16(frame_q.mic1_sample);
		mags[PK_MIC2]  = mag16(frame_q.mic2_pcm);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (frame_valid) state_nxt = ST_START;
			ST_START:  state_nxt = ST_RUN;
			ST_RUN:    if (!mul_busy && !div_busy) state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_EMIT;
			ST_EMIT:   if (!result_valid_q || !result_stall) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		frame_stall = (state_q != ST_IDLE);
		mul_start   = (state_q == ST_START);
		div_start   = (state_q == ST_START) && blk_start_q;
		peak_en     = (state_q == ST_UPDATE);
		emit_load   = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Gain ramp and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_gain_q <= '0;
			acc_q          <= '0;
			inc_q          <= '0;
			frames_left_q  <= '0;
			blk_start_q    <= 1'b0;
			last_q         <= 1'b0;
		end else if (accept) begin
			blk_start_q <= (frames_left_q == '0);
			if (frames_left_q == '0) begin
				acc_q          <= $signed({1'b0, applied_gain_q, {FRAC_W{1'b0}}});
				applied_gain_q <= target;
				frames_left_q  <= len_clamp;
			end
		end else if (state_q == ST_UPDATE) begin
			acc_q         <= acc_q + inc_now;
			inc_q         <= inc_now;
			frames_left_q <= frames_left_q - 1'b1;
			last_q        <= (frames_left_q == BLOCK_MIN);
		end
	end

	// Hold frame and divider operands
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= frame;
			if (frames_left_q == '0) begin
				div_neg_q <= gain_diff[GAIN_W];
				div_mag_q <= gain_diff[GAIN_W] ? GAIN_W'(-gain_diff) : gain_diff[GAIN_W-1:0];
			end
		end
		if (state_q == ST_UPDATE) begin
			out_sample_q <= o_sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.out_sample <= out_sample_q;
			result_q.block_end  <= last_q;
			result_q.peak_mono  <= last_q ? peaks[PK_MONO]  : '0;
			result_q.peak_left  <= last_q ? peaks[PK_LEFT]  : '0;
			result_q.peak_right <= last_q ? peaks[PK_RIGHT] : '0;
			result_q.peak_mic1  <= last_q ? peaks[PK_MIC1]  : '0;
			result_q.peak_mic2  <= last_q ? peaks[PK_MIC2]  : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	sdgr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mono_mag),
		.mplier  (acc_q[ACC_W-2:FRAC_W]),
		.busy    (mul_busy),
		.product (product)
	);

	sdgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.neg      (div_neg_q),
		.dividend ({div_mag_q, {FRAC_W{1'b0}}}),
		.divisor  (frames_left_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	sdgr_peak u_peak (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (peak_en),
		.clr    (blk_start_q),
		.mags   (mags),
		.peaks  (peaks)
	);

endmodule

/* rtl/core/sdgr_chk.sv */
// Port-level checker for the downmix, gain ramp and peak meter block, with its bind.
`timescale 1ns / 1ps

module sdgr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               frame_valid,
	input logic               frame_stall,
	input logic               result_valid,
	input logic               result_stall,
	input sdgr_pkg::result_t  result
);
	import sdgr_pkg::*;

	// A stalled result transaction holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// One frame at a time: the cycle after a frame transaction is stalled
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall |=> frame_stall)
		else $error("frame taken while previous frame in work");

	// Peaks only show on the last frame of a block
	a_peaks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.block_end |->
			result.peak_mono == '0 && result.peak_left == '0 &&
			result.peak_right == '0 && result.peak_mic1 == '0 &&
			result.peak_mic2 == '0)
		else $error("peak fields nonzero before block end");

	// Gain below unity never reaches the most negative code
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.out_sample != OUT_MIN[SAMPLE_W-1:0])
		else $error("output sample out of range");

endmodule

bind stereo_downmix_gain_ramp_peak_meter sdgr_chk u_sdgr_chk (.*);

/* test/downmix_ramp_checker.sv */
// Checker for the downmix gain ramp peak meter: predicts each result and compares it.
`timescale 1ns / 1ps

module downmix_ramp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sdgr_pkg::ADDR_W-1:0] paddr,
	input  logic [sdgr_pkg::APB_W-1:0]  pwdata,
	input  logic [sdgr_pkg::APB_W-1:0]  prdata,
	input  logic                        pready,
	input  logic                        frame_valid,
	input  logic                        frame_stall,
	input  sdgr_pkg::frame_t            frame,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  sdgr_pkg::result_t           result,
	output int                          errors,
	output int                          outstanding,
	output int                          frames_checked,
	output int                          blocks_checked
);

	import sdgr_pkg::*;

	// Gain accumulator holds Q15 gain times 65536; products rescale by 32768
	localparam int RAMP_ONE = 1 << FRAC_W;
	localparam int Q15_ONE  = 1 << GAIN_W;

	// Register copies and ramp state
	int user_gain_q;
	int music_on_q;
	int applied_gain;
	int ramp_acc;
	int ramp_step;
	int frames_left;
	int peak_mag[N_PEAKS];

	result_t pending_q[$];

	function automatic int magnitude(input int x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic logic [PEAK_W-1:0] clip_peak(input int p);
		return (p > int'(PEAK_SAT)) ? PEAK_SAT : p[PEAK_W-1:0];
	endfunction

	// Advance the ramp and meters by one frame and build its result
	function automatic result_t predict_frame(input frame_t f);
		int smp[N_PEAKS];
		int len;
		int target;
		int gain;
		int scaled;
		logic last;
		result_t r;
		smp[PK_LEFT]  = int'(f.left_pcm);
		smp[PK_RIGHT] = int'(f.right_pcm);
		smp[PK_MIC1]  = int'(f.mic1_sample);
		smp[PK_MIC2]  = int'(f.mic2_pcm);
		smp[PK_MONO]  = (smp[PK_LEFT] + smp[PK_RIGHT]) / 2;

		// Block start: latch length, fix the ramp, clear the meters
		if (frames_left == 0) begin
			len = int'(f.block_length);
			if (len > int'(BLOCK_MAX))
				len = int'(BLOCK_MAX);
			if (len < int'(BLOCK_MIN))
				len = int'(BLOCK_MIN);
			target = music_on_q ? user_gain_q : 0;
			ramp_acc = applied_gain * RAMP_ONE;
			ramp_step = ((target - applied_gain) * RAMP_ONE) / len;
			applied_gain = target;
			frames_left = len;
			for (int k = 0; k < N_PEAKS; k++)
				peak_mag[k] = 0;
		end

		gain = ramp_acc / RAMP_ONE;
		scaled = (smp[PK_MONO] * gain) / Q15_ONE;
		if (scaled > int'(OUT_MAX))
			scaled = int'(OUT_MAX);
		else if (scaled < int'(OUT_MIN))
			scaled = int'(OUT_MIN);

		for (int k = 0; k < N_PEAKS; k++)
			if (magnitude(smp[k]) > peak_mag[k])
				peak_mag[k] = magnitude(smp[k]);

		ramp_acc += ramp_step;
		frames_left--;
		last = (frames_left == 0);

		r.out_sample = scaled[SAMPLE_W-1:0];
		r.block_end  = last;
		r.peak_mono  = last ? clip_peak(peak_mag[PK_MONO]) : '0;
		r.peak_left  = last ? clip_peak(peak_mag[PK_LEFT]) : '0;
		r.peak_right = last ? clip_peak(peak_mag[PK_RIGHT]) : '0;
		r.peak_mic1  = last ? clip_peak(peak_mag[PK_MIC1]) : '0;
		r.peak_mic2  = last ? clip_peak(peak_mag[PK_MIC2]) : '0;
		return r;
	endfunction

	function automatic int check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic int compare_result(input result_t want, input result_t got);
		int bad;
		bad = 0;
		bad += check_field("out_sample", 32'($signed(want.out_sample)),
			32'($signed(got.out_sample)));
		bad += check_field("block_end", 32'(want.block_end), 32'(got.block_end));
		bad += check_field("peak_mono", 32'(want.peak_mono), 32'(got.peak_mono));
		bad += check_field("peak_left", 32'(want.peak_left), 32'(got.peak_left));
		bad += check_field("peak_right", 32'(want.peak_right), 32'(got.peak_right));
		bad += check_field("peak_mic1", 32'(want.peak_mic1), 32'(got.peak_mic1));
		bad += check_field("peak_mic2", 32'(want.peak_mic2), 32'(got.peak_mic2));
		return bad;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			user_gain_q = 0;
			music_on_q = 0;
			applied_gain = 0;
			ramp_acc = 0;
			ramp_step = 0;
			frames_left = 0;
			for (int k = 0; k < N_PEAKS; k++)
				peak_mag[k] = 0;
			pending_q.delete();
			errors = 0;
			outstanding = 0;
			frames_checked = 0;
			blocks_checked = 0;
		end else begin
			// Track register writes, check register reads
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[2])
						REG_SEL_USER_GAIN: user_gain_q = int'(pwdata[GAIN_W-1:0]);
						REG_SEL_MUSIC_ON:  music_on_q = int'(pwdata[0]);
						default: ;
					endcase
				end else begin
					case (paddr[2])
						REG_SEL_USER_GAIN:
							errors += check_field("user_gain", user_gain_q,
								32'(prdata[GAIN_W-1:0]));
						REG_SEL_MUSIC_ON:
							errors += check_field("music_on", music_on_q,
								32'(prdata[0]));
						default: ;
					endcase
				end
			end

			// Compare each accepted result with the oldest prediction
			if (result_valid && !result_stall) begin
				if (pending_q.size() == 0) begin
					$error("result transaction with no frame outstanding: out_sample %0d",
						$signed(result.out_sample));
					errors++;
				end else begin
					want = pending_q.pop_front();
					errors += compare_result(want, result);
					frames_checked++;
					if (want.block_end)
						blocks_checked++;
				end
			end

			// Predict each accepted frame
			if (frame_valid && !frame_stall)
				pending_q.push_back(predict_frame(frame));

			outstanding = pending_q.size();
		end
	end

endmodule

/* test/tb_top.sv */
// Testbench top: drives frames, register accesses and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module tb_top;

	import sdgr_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_USER_GAIN = {REG_SEL_USER_GAIN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_MUSIC_ON  = {REG_SEL_MUSIC_ON, 2'b00};
	localparam int CHUNKS       = 12;
	localparam int CHUNK_FRAMES = 105;
	localparam int HOLD_CYCLES  = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0]  pwdata = '0;
	logic [APB_W-1:0]  prdata;
	logic              pready;
	logic              frame_valid = 1'b0;
	logic              frame_stall;
	frame_t            frame = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;

	int errors;
	int outstanding;
	int frames_checked;
	int blocks_checked;

	int tx_idle = 0;
	int rx_idle = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int settings_used = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stereo_downmix_gain_ramp_peak_meter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	downmix_ramp_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame          (frame),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.errors         (errors),
		.outstanding    (outstanding),
		.frames_checked (frames_checked),
		.blocks_checked (blocks_checked)
	);

	// Stall the output at random; hold it off for a long stretch on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < rx_idle);
		end
	end

	// One register port access; leaves psel high for a following access
	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [APB_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// Write both registers with random upper bits, read them back, release the bus
	task automatic set_config(input int gain, input int on);
		apb_access(1'b1, ADDR_USER_GAIN, ($urandom() & ~32'h7FFF) | 32'(gain[GAIN_W-1:0]));
		apb_access(1'b1, ADDR_MUSIC_ON, ($urandom() & ~32'h1) | 32'(on[0]));
		apb_access(1'b0, ADDR_USER_GAIN, $urandom());
		apb_access(1'b0, ADDR_MUSIC_ON, $urandom());
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
		@(negedge clk);
	endtask

	// Offer one frame transaction after a random gap; valid stays up until the next call
	task automatic send_frame(input frame_t f);
		while ($urandom_range(0, 99) < tx_idle) begin
			frame_valid <= 1'b0;
			@(negedge clk);
		end
		frame_valid <= 1'b1;
		frame <= f;
		do @(posedge clk); while (frame_stall);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has come out
	task automatic wait_drained();
		frame_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	function automatic frame_t make_frame(input int l, input int r, input int m1, input int m2,
			input int len);
		frame_t f;
		f.left_pcm     = l[SAMPLE_W-1:0];
		f.right_pcm    = r[SAMPLE_W-1:0];
		f.mic1_sample  = m1[SAMPLE_W-1:0];
		f.mic2_pcm     = m2[SAMPLE_W-1:0];
		f.block_length = len[LEN_W-1:0];
		return f;
	endfunction

	// Favor full-scale and near-zero samples over plain random ones
	function automatic int rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       return -32768;
			1:       return 32767;
			2, 3:    return int'($urandom_range(0, 600)) - 300;
			default: return int'($signed(16'($urandom())));
		endcase
	endfunction

	// Mostly short blocks, now and then long or out-of-range lengths
	function automatic int rand_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(0, 12);
		else if (pick < 95)
			return $urandom_range(13, 64);
		return $urandom_range(65, 511);
	endfunction

	function automatic frame_t rand_frame();
		return make_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
			rand_length());
	endfunction

	initial begin
		int gain;
		int on;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full-scale samples, zero and one frame blocks
		set_config(32767, 1);
		send_frame(make_frame(32767, 32767, -32768, 32767, 0));
		send_frame(make_frame(-32768, -32768, -32768, -32768, 1));

		// Register change in the middle of a block must wait for the next block
		send_frame(make_frame(32767, -32768, 0, -1, 4));
		send_frame(make_frame(-1, 0, 1, 32767, 0));
		wait_drained();
		set_config(0, 1);
		send_frame(make_frame(-32768, 32767, -32767, 5, 300));
		send_frame(make_frame(1, 1, -2, 2, 511));

		// Mute: ramp from full gain down to silence
		wait_drained();
		set_config(20000, 0);
		send_frame(make_frame(30000, 29000, 100, -100, 3));
		send_frame(make_frame(-30000, -31000, 32767, -32768, 7));
		send_frame(make_frame(12345, -5432, -1, 0, 9));

		// Ramp up from silence, then a quiet block
		wait_drained();
		set_config(12345, 1);
		send_frame(make_frame(32767, 32767, 0, 0, 2));
		send_frame(make_frame(-32768, -32767, 0, 0, 0));
		for (int i = 0; i < 5; i++)
			send_frame(make_frame(0, 0, 0, 0, 5));
		wait_drained();

		// Random: three idle mixes, four register settings each
		for (int c = 0; c < CHUNKS; c++) begin
			if (c % 4 == 0) begin
				case (c / 4)
					0: begin
						tx_idle = 30;
						rx_idle <= 64;
					end
					1: begin
						tx_idle = 64;
						rx_idle <= 30;
					end
					default: begin
						tx_idle = 0;
						rx_idle <= 0;
					end
				endcase
			end
			case (c % 4)
				0:       gain = 32767;
				1:       gain = 0;
				2:       gain = $urandom_range(1, 32766);
				default: gain = $urandom_range(0, 32767);
			endcase
			on = (c % 3 == 2) ? 0 : 1;
			wait_drained();
			set_config(gain, on);
			if (c == 1 || c == 9)
				hold_req <= hold_req + 1;
			for (int i = 0; i < CHUNK_FRAMES; i++)
				send_frame(rand_frame());
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Run covered %0d frames in %0d blocks under %0d register settings,",
			frames_checked, blocks_checked, settings_used);
		$display("three sender/receiver idle mixes and two long output holds.");
		if (errors == 0 && outstanding == 0)
			$display("stereo_downmix_gain_ramp_peak_meter regression: pass");
		else
			$display("stereo_downmix_gain_ramp_peak_meter regression: fail");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("stereo_downmix_gain_ramp_peak_meter regression: fail");
		$finish;
	end

endmodule
